// File: rtl/gesac_pkg.sv
`default_nettype none
package gesac_pkg;

    // sizes
    localparam int MAX_NODES = 64;
    localparam int MAX_EDGES = 256;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int EDGE_W    = $clog2(MAX_EDGES);
    localparam int QPTR_W    = NODE_W + 1;
    localparam int DEG_W     = 10;
    localparam int CNT_W     = 9;
    localparam int CFG_W     = 7;
    localparam int REQ_W     = 3;
    localparam int STAT_W    = 2;

    // request codes
    typedef logic [REQ_W-1:0] t_req;
    localparam t_req REQ_INSERT   = 3'd0;
    localparam t_req REQ_DEL_EDGE = 3'd1;
    localparam t_req REQ_UNLINK   = 3'd2;
    localparam t_req REQ_DEL_NODE = 3'd3;
    localparam t_req REQ_QUERY    = 3'd4;
    localparam t_req REQ_OUTDEG   = 3'd5;
    localparam t_req REQ_CHECK    = 3'd6;
    localparam t_req REQ_NONE     = 3'd7;

    // status codes
    typedef logic [STAT_W-1:0] t_status;
    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_RANGE    = 2'd1;
    localparam t_status ST_FULL     = 2'd2;
    localparam t_status ST_NOTFOUND = 2'd3;

    // signed degree counts
    typedef logic signed [DEG_W-1:0] t_deg;
    localparam t_deg DEG_MIN     = t_deg'(-512);
    localparam t_deg DEG_MAX     = t_deg'(511);
    localparam t_deg DEG_REMOVED = t_deg'(-1);

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_DEG_RD,
        S_DEG_WR,
        S_FIN_NODE,
        S_KINIT_RD,
        S_KINIT_WR,
        S_KPOP_RD,
        S_KPOP_WR,
        S_KSCAN_RD,
        S_KSCAN_CHK,
        S_KDEG_RD,
        S_KDEG_WR,
        S_DONE
    } t_state;

    function automatic t_deg deg_inc(input t_deg x);
        return (x < DEG_MAX) ? t_deg'(x + t_deg'(1)) : x;
    endfunction

    function automatic t_deg deg_dec(input t_deg x);
        return (x > DEG_MIN) ? t_deg'(x - t_deg'(1)) : x;
    endfunction

endpackage
`default_nettype wire

// File: rtl/gesac_if.sv
`default_nettype none
interface gesac_req_if;
    logic                         valid;
    logic                         ready;
    logic [gesac_pkg::REQ_W-1:0]  req_type;
    logic [gesac_pkg::NODE_W-1:0] src_node;
    logic [gesac_pkg::NODE_W-1:0] dst_node;
    modport source (output valid, req_type, src_node, dst_node, input ready);
    modport sink   (input valid, req_type, src_node, dst_node, output ready);
endinterface

interface gesac_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [gesac_pkg::STAT_W-1:0] status;
    logic                         flag;
    logic [gesac_pkg::CNT_W-1:0]  count;
    modport source (output valid, status, flag, count, input ready);
    modport sink   (input valid, status, flag, count, output ready);
endinterface
`default_nettype wire

// File: rtl/graph_edge_store_acyclic_check_top.sv
// Directed multigraph edge store with an acyclic check.
// Requests arrive on i_req (valid/ready, one beat per request); each gives
// exactly one response beat on o_rsp (status, flag, count).
// Requests are handled one at a time; i_req.ready is high while the
// sequencer is idle, also while a finished response still waits in the
// output register.
// The edge memory has one read port, so every table walk reads and then
// checks one entry at a time. An out-of-range or unknown request answers
// without a walk; insert, delete edge, unlink, query and out-degree walk
// the edge table at most once, delete node walks it once with a degree
// update per removed edge. The acyclic check copies the in-degrees, then
// walks the whole table for each processed node.
// Reset (synchronous, active low) and a node count write start a clearing
// pass over the whole edge table that invalidates every edge and zeroes the
// in-degrees; i_req.ready stays low during the pass.
// If the receiver stalls, the response is held in the output register
// and a finished later request waits until that register is free.
`default_nettype none
module graph_edge_store_acyclic_check_top (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [gesac_pkg::CFG_W-1:0]  i_cfg_data,
    gesac_req_if.sink                         i_req,
    gesac_rsp_if.source                       o_rsp
);

    localparam int NW = gesac_pkg::NODE_W;
    localparam int EW = gesac_pkg::EDGE_W;
    localparam int QW = gesac_pkg::QPTR_W;
    localparam int CW = gesac_pkg::CNT_W;
    localparam int FW = gesac_pkg::CFG_W;

    // state
    gesac_pkg::t_state r_state, n_state;

    // request and working registers
    gesac_pkg::t_req    r_req, n_req;
    logic [NW-1:0]      r_src, n_src;
    logic [NW-1:0]      r_dst, n_dst;
    logic [EW-1:0]      r_idx, n_idx;
    logic [NW-1:0]      r_deg_addr, n_deg_addr;
    logic [NW-1:0]      r_u, n_u;
    logic [QW-1:0]      r_kidx, n_kidx;
    logic [QW-1:0]      r_head, n_head;
    logic [QW-1:0]      r_tail, n_tail;
    logic [CW-1:0]      r_count, n_count;
    logic               r_flag, n_flag;
    gesac_pkg::t_status r_status, n_status;
    logic [FW-1:0]      r_num_nodes;
    logic [FW-1:0]      r_live, n_live;

    // output register
    logic               r_out_valid;
    gesac_pkg::t_status r_out_status;
    logic               r_out_flag;
    logic [CW-1:0]      r_out_count;

    // memories; an edge entry is {valid, src, dst}
    logic [2*NW:0]       edge_mem  [gesac_pkg::MAX_EDGES];
    gesac_pkg::t_deg     deg_mem   [gesac_pkg::MAX_NODES];
    gesac_pkg::t_deg     work_mem  [gesac_pkg::MAX_NODES];
    logic [NW-1:0]       queue_mem [gesac_pkg::MAX_NODES];
    logic [2*NW:0]       r_edge_rd;
    gesac_pkg::t_deg     r_deg_rd;
    gesac_pkg::t_deg     r_work_rd;
    logic [NW-1:0]       r_queue_rd;

    // memory controls
    logic            edge_we;
    logic [2*NW:0]   edge_wdata;
    logic            deg_we;
    logic [NW-1:0]   deg_wr_addr;
    gesac_pkg::t_deg deg_wdata;
    logic [NW-1:0]   deg_rd_addr;
    logic            work_we;
    gesac_pkg::t_deg work_wdata;
    logic            queue_we;
    logic [NW-1:0]   queue_wdata;

    // decoded conditions
    logic            accept;
    logic            need_s, need_d, bad_node;
    logic            last;
    logic            edge_live;
    logic            src_hit, full_hit, ku_hit;
    logic [NW-1:0]   edge_src, edge_dst;
    gesac_pkg::t_deg deg_cur, deg_new, work_new;
    logic            queue_room;
    logic            kinit_end;
    logic            out_free;
    logic [FW-1:0]   cfg_clamped;

    assign accept    = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == gesac_pkg::S_IDLE);
    assign out_free  = !r_out_valid || o_rsp.ready;

    assign need_s = (i_req.req_type <= gesac_pkg::REQ_OUTDEG);
    assign need_d = (i_req.req_type == gesac_pkg::REQ_INSERT)
                 || (i_req.req_type == gesac_pkg::REQ_DEL_EDGE)
                 || (i_req.req_type == gesac_pkg::REQ_UNLINK)
                 || (i_req.req_type == gesac_pkg::REQ_QUERY);
    assign bad_node = (need_s && ({1'b0, i_req.src_node} >= r_num_nodes))
                   || (need_d && ({1'b0, i_req.dst_node} >= r_num_nodes));

    assign last      = (r_idx == EW'(gesac_pkg::MAX_EDGES - 1));
    assign edge_live = r_edge_rd[2*NW];
    assign edge_src  = r_edge_rd[2*NW-1:NW];
    assign edge_dst  = r_edge_rd[NW-1:0];
    assign src_hit   = edge_live && (edge_src == r_src);
    assign full_hit  = src_hit && (edge_dst == r_dst);
    assign ku_hit    = edge_live && (edge_src == r_u);
    assign deg_cur   = r_deg_rd;
    assign deg_new  = (r_req == gesac_pkg::REQ_INSERT) ? gesac_pkg::deg_inc(deg_cur)
                                                      : gesac_pkg::deg_dec(deg_cur);
    assign work_new   = gesac_pkg::deg_dec(r_work_rd);
    assign queue_room = !r_tail[QW-1];
    assign kinit_end  = ((r_kidx + QW'(1)) == r_num_nodes);

    // clamp of the node count write
    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_clamped = FW'(1);
        end else if (i_cfg_data > FW'(gesac_pkg::MAX_NODES)) begin
            cfg_clamped = FW'(gesac_pkg::MAX_NODES);
        end else begin
            cfg_clamped = i_cfg_data;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gesac_pkg::S_CLEAR: begin
                if (last) begin
                    n_state = gesac_pkg::S_IDLE;
                end
            end
            gesac_pkg::S_IDLE: begin
                if (accept) begin
                    if (bad_node) begin
                        n_state = gesac_pkg::S_DONE;
                    end else begin
                        unique case (i_req.req_type) inside
                            gesac_pkg::REQ_INSERT, gesac_pkg::REQ_UNLINK,
                            gesac_pkg::REQ_DEL_NODE, gesac_pkg::REQ_QUERY,
                            gesac_pkg::REQ_OUTDEG:
                                n_state = gesac_pkg::S_SCAN_RD;
                            gesac_pkg::REQ_DEL_EDGE: n_state = gesac_pkg::S_DEG_RD;
                            gesac_pkg::REQ_CHECK:    n_state = gesac_pkg::S_KINIT_RD;
                            default:                 n_state = gesac_pkg::S_DONE;
                        endcase
                    end
                end
            end
            gesac_pkg::S_SCAN_RD: n_state = gesac_pkg::S_SCAN_CHK;
            gesac_pkg::S_SCAN_CHK: begin
                if (r_req == gesac_pkg::REQ_INSERT) begin
                    if (!edge_live) begin
                        n_state = gesac_pkg::S_DEG_RD;
                    end else if (last) begin
                        n_state = gesac_pkg::S_DONE;
                    end else begin
                        n_state = gesac_pkg::S_SCAN_RD;
                    end
                end else if (r_req == gesac_pkg::REQ_DEL_NODE) begin
                    if (src_hit) begin
                        n_state = gesac_pkg::S_DEG_RD;
                    end else if (last) begin
                        n_state = gesac_pkg::S_FIN_NODE;
                    end else begin
                        n_state = gesac_pkg::S_SCAN_RD;
                    end
                end else if (r_req == gesac_pkg::REQ_OUTDEG) begin
                    n_state = last ? gesac_pkg::S_DONE : gesac_pkg::S_SCAN_RD;
                end else begin
                    n_state = (full_hit || last) ? gesac_pkg::S_DONE : gesac_pkg::S_SCAN_RD;
                end
            end
            gesac_pkg::S_DEG_RD: n_state = gesac_pkg::S_DEG_WR;
            gesac_pkg::S_DEG_WR: begin
                if (r_req == gesac_pkg::REQ_INSERT) begin
                    n_state = gesac_pkg::S_DONE;
                end else if (r_req == gesac_pkg::REQ_DEL_NODE && last) begin
                    n_state = gesac_pkg::S_FIN_NODE;
                end else begin
                    n_state = gesac_pkg::S_SCAN_RD;
                end
            end
            gesac_pkg::S_FIN_NODE: n_state = gesac_pkg::S_DONE;
            gesac_pkg::S_KINIT_RD: n_state = gesac_pkg::S_KINIT_WR;
            gesac_pkg::S_KINIT_WR: begin
                n_state = kinit_end ? gesac_pkg::S_KPOP_RD : gesac_pkg::S_KINIT_RD;
            end
            gesac_pkg::S_KPOP_RD: begin
                n_state = (r_head < r_tail) ? gesac_pkg::S_KPOP_WR : gesac_pkg::S_DONE;
            end
            gesac_pkg::S_KPOP_WR:  n_state = gesac_pkg::S_KSCAN_RD;
            gesac_pkg::S_KSCAN_RD: n_state = gesac_pkg::S_KSCAN_CHK;
            gesac_pkg::S_KSCAN_CHK: begin
                if (ku_hit) begin
                    n_state = gesac_pkg::S_KDEG_RD;
                end else begin
                    n_state = last ? gesac_pkg::S_KPOP_RD : gesac_pkg::S_KSCAN_RD;
                end
            end
            gesac_pkg::S_KDEG_RD: n_state = gesac_pkg::S_KDEG_WR;
            gesac_pkg::S_KDEG_WR: begin
                n_state = last ? gesac_pkg::S_KPOP_RD : gesac_pkg::S_KSCAN_RD;
            end
            gesac_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = gesac_pkg::S_IDLE;
                end
            end
            default: n_state = gesac_pkg::S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_req      = r_req;
        n_src      = r_src;
        n_dst      = r_dst;
        n_idx      = r_idx;
        n_deg_addr = r_deg_addr;
        n_u        = r_u;
        n_kidx     = r_kidx;
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_flag     = r_flag;
        n_status   = r_status;
        n_live     = r_live;
        edge_we     = 1'b0;
        edge_wdata  = {1'b1, r_src, r_dst};
        deg_we      = 1'b0;
        deg_wr_addr = r_deg_addr;
        deg_wdata   = deg_new;
        deg_rd_addr = r_deg_addr;
        work_we     = 1'b0;
        work_wdata  = work_new;
        queue_we    = 1'b0;
        queue_wdata = r_deg_addr;
        unique case (r_state)
            gesac_pkg::S_CLEAR: begin
                // one edge entry per cycle, in-degrees ride along
                edge_we     = 1'b1;
                edge_wdata  = '0;
                deg_we      = 1'b1;
                deg_wr_addr = r_idx[NW-1:0];
                deg_wdata   = '0;
                n_idx       = r_idx + EW'(1);
            end
            gesac_pkg::S_IDLE: begin
                if (accept) begin
                    n_req      = i_req.req_type;
                    n_src      = i_req.src_node;
                    n_dst      = i_req.dst_node;
                    n_idx      = '0;
                    n_deg_addr = i_req.dst_node;
                    n_kidx     = '0;
                    n_head     = '0;
                    n_tail     = '0;
                    n_count    = '0;
                    n_flag     = 1'b0;
                    n_status   = bad_node ? gesac_pkg::ST_RANGE : gesac_pkg::ST_OK;
                end
            end
            gesac_pkg::S_SCAN_CHK: begin
                if (r_req == gesac_pkg::REQ_INSERT) begin
                    if (!edge_live) begin
                        edge_we = 1'b1;
                    end else if (last) begin
                        n_status = gesac_pkg::ST_FULL;
                    end else begin
                        n_idx = r_idx + EW'(1);
                    end
                end else if (r_req == gesac_pkg::REQ_DEL_NODE) begin
                    if (src_hit) begin
                        edge_we    = 1'b1;
                        edge_wdata = '0;
                        n_deg_addr = edge_dst;
                    end else if (!last) begin
                        n_idx = r_idx + EW'(1);
                    end
                end else if (r_req == gesac_pkg::REQ_OUTDEG) begin
                    if (src_hit) begin
                        n_count = r_count + CW'(1);
                    end
                    if (!last) begin
                        n_idx = r_idx + EW'(1);
                    end
                end else if (full_hit) begin
                    if (r_req == gesac_pkg::REQ_QUERY) begin
                        n_flag = 1'b1;
                    end else begin
                        edge_we    = 1'b1;
                        edge_wdata = '0;
                    end
                end else if (last) begin
                    if (r_req != gesac_pkg::REQ_QUERY) begin
                        n_status = gesac_pkg::ST_NOTFOUND;
                    end
                end else begin
                    n_idx = r_idx + EW'(1);
                end
            end
            gesac_pkg::S_DEG_WR: begin
                deg_we = 1'b1;
                if (r_req == gesac_pkg::REQ_DEL_NODE && !last) begin
                    n_idx = r_idx + EW'(1);
                end
            end
            gesac_pkg::S_FIN_NODE: begin
                deg_we      = 1'b1;
                deg_wr_addr = r_src;
                deg_wdata   = gesac_pkg::DEG_REMOVED;
                if (r_live != '0) begin
                    n_live = r_live - FW'(1);
                end
            end
            gesac_pkg::S_KINIT_RD: begin
                deg_rd_addr = r_kidx[NW-1:0];
            end
            gesac_pkg::S_KINIT_WR: begin
                work_we     = 1'b1;
                work_wdata  = deg_cur;
                queue_wdata = r_kidx[NW-1:0];
                if (deg_cur == '0 && queue_room) begin
                    queue_we = 1'b1;
                    n_tail   = r_tail + QW'(1);
                end
                n_kidx = r_kidx + QW'(1);
            end
            gesac_pkg::S_KPOP_RD: begin
                if (!(r_head < r_tail)) begin
                    n_flag = (r_count == CW'(r_live));
                end
            end
            gesac_pkg::S_KPOP_WR: begin
                n_u     = r_queue_rd;
                n_head  = r_head + QW'(1);
                n_count = r_count + CW'(1);
                n_idx   = '0;
            end
            gesac_pkg::S_KSCAN_CHK: begin
                if (ku_hit) begin
                    n_deg_addr = edge_dst;
                end else if (!last) begin
                    n_idx = r_idx + EW'(1);
                end
            end
            gesac_pkg::S_KDEG_WR: begin
                work_we = 1'b1;
                if (work_new == '0 && queue_room) begin
                    queue_we = 1'b1;
                    n_tail   = r_tail + QW'(1);
                end
                if (!last) begin
                    n_idx = r_idx + EW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // control registers and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gesac_pkg::S_CLEAR;
            r_idx       <= '0;
            r_num_nodes <= FW'(gesac_pkg::MAX_NODES);
            r_live      <= FW'(gesac_pkg::MAX_NODES);
            r_head      <= '0;
            r_tail      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            if (i_cfg_we) begin
                r_state     <= gesac_pkg::S_CLEAR;
                r_idx       <= '0;
                r_num_nodes <= cfg_clamped;
                r_live      <= cfg_clamped;
            end else begin
                r_state <= n_state;
                r_idx   <= n_idx;
                r_live  <= n_live;
            end
            // response beat
            if (r_state == gesac_pkg::S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_src      <= n_src;
        r_dst      <= n_dst;
        r_deg_addr <= n_deg_addr;
        r_u        <= n_u;
        r_kidx     <= n_kidx;
        r_count    <= n_count;
        r_flag     <= n_flag;
        r_status   <= n_status;
        if (r_state == gesac_pkg::S_DONE && out_free) begin
            r_out_status <= r_status;
            r_out_flag   <= r_flag;
            r_out_count  <= r_count;
        end
    end

    // edge table memory
    always_ff @(posedge i_clk) begin
        if (edge_we) begin
            edge_mem[r_idx] <= edge_wdata;
        end
        r_edge_rd <= edge_mem[r_idx];
    end

    // in-degree memory
    always_ff @(posedge i_clk) begin
        if (deg_we) begin
            deg_mem[deg_wr_addr] <= deg_wdata;
        end
        r_deg_rd <= deg_mem[deg_rd_addr];
    end

    // working degree memory
    always_ff @(posedge i_clk) begin
        if (work_we) begin
            if (r_state == gesac_pkg::S_KINIT_WR) begin
                work_mem[r_kidx[NW-1:0]] <= work_wdata;
            end else begin
                work_mem[r_deg_addr] <= work_wdata;
            end
        end
        r_work_rd <= work_mem[r_deg_addr];
    end

    // ready queue memory
    always_ff @(posedge i_clk) begin
        if (queue_we) begin
            queue_mem[r_tail[NW-1:0]] <= queue_wdata;
        end
        r_queue_rd <= queue_mem[r_head[NW-1:0]];
    end

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.status = r_out_status;
    assign o_rsp.flag   = r_out_flag;
    assign o_rsp.count  = r_out_count;

    // queue pointers stay ordered and bounded
    a_head_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= r_tail) else $error("ready queue head passed tail");

    a_tail_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail <= QW'(gesac_pkg::MAX_NODES)) else $error("ready queue overflow");

    // live count never exceeds the configured node count
    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= r_num_nodes) else $error("live count above node count");

    // the check never counts more processed nodes than MAX_NODES
    a_kahn_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gesac_pkg::S_KPOP_WR) |=> (r_count <= CW'(gesac_pkg::MAX_NODES)))
        else $error("processed count out of range");

endmodule
`default_nettype wire
